// ===== design/descending_key_tag_quicksort_top_macros.svh =====
// Assertion macros shared by the quicksort block.
`ifndef DESCENDING_KEY_TAG_QUICKSORT_TOP_MACROS_SVH
`define DESCENDING_KEY_TAG_QUICKSORT_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DKTQS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DKTQS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/dktqs_pkg.sv =====
// Package with the item types and field widths of the quicksort block.
`default_nettype none
package dktqs_pkg;

  localparam int KEY_W = 32;
  localparam int TAG_W = 16;

  // One input item.
  typedef struct packed {
    logic signed [KEY_W-1:0] score;
    logic        [TAG_W-1:0] tag;
    logic                    last;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic signed [KEY_W-1:0] sorted_score;
    logic        [TAG_W-1:0] sorted_tag;
    logic                    final_res;
  } out_item_t;

  // One stored score and tag pair.
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic        [TAG_W-1:0] tag;
  } pair_t;

endpackage
`default_nettype wire

// ===== design/descending_key_tag_quicksort_top.sv =====
// Descending quicksort of score and tag pairs around a pair store and a range stack.
// Items are taken one per cycle and stored until one marked last arrives; an item that
// arrives while MAX_ITEMS pairs are stored is dropped, though its last mark still counts.
// The set is then sorted in place by a Lomuto quicksort (last element as pivot, score >=
// pivot goes left, pending ranges on a stack) and every pair is emitted in descending
// order, the final one with final_res set. The pair store is kept as two copies written
// together, so the elements at i and j are read in the same cycle; its single write port
// sets the speed. Each range is popped from the stack and its pivot read, then every
// element is read and compared with the pivot, one that goes left taking a further swap
// step, and the right and left parts are pushed in turn. Each pair is read and then held
// on the output until taken; the next pair is read only after that.
// No input is taken from the last item until the final result is taken.
`default_nettype none
`include "descending_key_tag_quicksort_top_macros.svh"
module descending_key_tag_quicksort_top #(
  parameter int MAX_ITEMS = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire dktqs_pkg::in_item_t  in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output dktqs_pkg::out_item_t      out_data
);

  localparam int IDX_W  = $clog2(MAX_ITEMS);
  localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam int STK_W  = 2 * IDX_W;
  localparam int PAIR_W = $bits(dktqs_pkg::pair_t);

  typedef enum logic [3:0] {
    S_LOAD, S_CHK, S_POP, S_POPD, S_PIV, S_RD, S_CMP, S_SWJ,
    S_PUSH1, S_PUSH2, S_ORD, S_OWAIT, S_OHOLD
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [CNT_W-1:0]        sp_r, sp_nxt;
  logic [IDX_W-1:0]        lo_r, lo_nxt;
  logic [IDX_W-1:0]        hi_r, hi_nxt;
  logic [CNT_W-1:0]        i_r, i_nxt;
  logic [CNT_W-1:0]        j_r, j_nxt;
  logic [CNT_W-1:0]        k_r, k_nxt;
  logic signed [dktqs_pkg::KEY_W-1:0] pivot_r, pivot_nxt;
  dktqs_pkg::out_item_t    out_r, out_nxt;
  logic                    out_valid_r, out_valid_nxt;

  // Pair store and range stack ports.
  logic                    pwe;
  logic [IDX_W-1:0]        pwa;
  dktqs_pkg::pair_t        pwd;
  logic [IDX_W-1:0]        ra_a;
  dktqs_pkg::pair_t        rd_a, rd_b;
  logic                    swe;
  logic [IDX_W-1:0]        swa;
  logic [STK_W-1:0]        swd;
  logic [IDX_W-1:0]        sra;
  logic [STK_W-1:0]        stk_rd;

  // Helper values.
  logic [CNT_W-1:0]        n_after;
  logic [CNT_W-1:0]        sp_m1;
  logic [IDX_W-1:0]        pop_lo, pop_hi;
  logic [CNT_W-1:0]        hi_w, lo_w;

  assign n_after = (cnt_r < CNT_W'(MAX_ITEMS)) ? CNT_W'(cnt_r + 1'b1) : cnt_r;
  assign sp_m1   = CNT_W'(sp_r - 1'b1);
  assign pop_lo  = stk_rd[STK_W-1:IDX_W];
  assign pop_hi  = stk_rd[IDX_W-1:0];
  assign hi_w    = CNT_W'(hi_r);
  assign lo_w    = CNT_W'(lo_r);

  // Pair store copy A: read at j (or the pivot or the emit index).
  dktqs_ram #(.WIDTH(PAIR_W), .DEPTH(MAX_ITEMS)) u_pair_a (
    .clk   (clk),
    .we    (pwe),
    .waddr (pwa),
    .wdata (pwd),
    .raddr (ra_a),
    .rdata (rd_a)
  );

  // Pair store copy B: read at i.
  dktqs_ram #(.WIDTH(PAIR_W), .DEPTH(MAX_ITEMS)) u_pair_b (
    .clk   (clk),
    .we    (pwe),
    .waddr (pwa),
    .wdata (pwd),
    .raddr (i_r[IDX_W-1:0]),
    .rdata (rd_b)
  );

  // Range stack: low index in the upper half, high index in the lower half.
  dktqs_ram #(.WIDTH(STK_W), .DEPTH(MAX_ITEMS)) u_stack (
    .clk   (clk),
    .we    (swe),
    .waddr (swa),
    .wdata (swd),
    .raddr (sra),
    .rdata (stk_rd)
  );

  // Sequencer: load, partition one range at a time, then emit.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    sp_nxt        = sp_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    pivot_nxt     = pivot_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    pwe           = 1'b0;
    pwa           = i_r[IDX_W-1:0];
    pwd           = rd_a;
    ra_a          = j_r[IDX_W-1:0];
    swe           = 1'b0;
    swa           = sp_r[IDX_W-1:0];
    swd           = {lo_r, hi_r};
    sra           = sp_m1[IDX_W-1:0];
    case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          if (cnt_r < CNT_W'(MAX_ITEMS)) begin
            pwe     = 1'b1;
            pwa     = cnt_r[IDX_W-1:0];
            pwd     = {in_data.score, in_data.tag};
            cnt_nxt = n_after;
          end
          if (in_data.last) begin
            k_nxt = '0;
            if (n_after >= CNT_W'(2)) begin
              // Whole set is the first range.
              swe       = 1'b1;
              swa       = '0;
              swd       = {{IDX_W{1'b0}}, IDX_W'(n_after - 1'b1)};
              sp_nxt    = CNT_W'(1);
              state_nxt = S_CHK;
            end else begin
              state_nxt = S_ORD;
            end
          end
        end
      end
      S_CHK: begin
        if (sp_r == '0) begin
          k_nxt     = '0;
          state_nxt = S_ORD;
        end else begin
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        sp_nxt    = sp_m1;
        state_nxt = S_POPD;
      end
      S_POPD: begin
        if ((pop_lo >= pop_hi) || (CNT_W'(pop_hi) >= cnt_r)) begin
          state_nxt = S_CHK;
        end else begin
          lo_nxt    = pop_lo;
          hi_nxt    = pop_hi;
          i_nxt     = CNT_W'(pop_lo);
          j_nxt     = CNT_W'(pop_lo);
          ra_a      = pop_hi;
          state_nxt = S_PIV;
        end
      end
      S_PIV: begin
        pivot_nxt = rd_a.key;
        state_nxt = S_RD;
      end
      S_RD: begin
        // Reads of j (copy A) and i (copy B) are issued here.
        state_nxt = S_CMP;
      end
      S_CMP: begin
        // The pivot itself always passes, which performs the closing swap.
        if (rd_a.key >= pivot_r) begin
          pwe       = 1'b1;
          pwa       = i_r[IDX_W-1:0];
          pwd       = rd_a;
          state_nxt = S_SWJ;
        end else begin
          j_nxt     = CNT_W'(j_r + 1'b1);
          state_nxt = S_RD;
        end
      end
      S_SWJ: begin
        pwe   = 1'b1;
        pwa   = j_r[IDX_W-1:0];
        pwd   = rd_b;
        i_nxt = CNT_W'(i_r + 1'b1);
        if (j_r == hi_w) begin
          state_nxt = S_PUSH1;
        end else begin
          j_nxt     = CNT_W'(j_r + 1'b1);
          state_nxt = S_RD;
        end
      end
      S_PUSH1: begin
        // Right part (pivot position + 1 .. hi); i now sits one past the pivot.
        if ((hi_w > i_r) && (sp_r < CNT_W'(MAX_ITEMS))) begin
          swe    = 1'b1;
          swd    = {i_r[IDX_W-1:0], hi_r};
          sp_nxt = CNT_W'(sp_r + 1'b1);
        end
        state_nxt = S_PUSH2;
      end
      S_PUSH2: begin
        // Left part (lo .. pivot position - 1), popped first.
        if ((i_r > CNT_W'(lo_w + 2'd2)) && (sp_r < CNT_W'(MAX_ITEMS))) begin
          swe    = 1'b1;
          swd    = {lo_r, IDX_W'(i_r - 2'd2)};
          sp_nxt = CNT_W'(sp_r + 1'b1);
        end
        state_nxt = S_CHK;
      end
      S_ORD: begin
        ra_a      = k_r[IDX_W-1:0];
        state_nxt = S_OWAIT;
      end
      S_OWAIT: begin
        out_nxt.sorted_score = rd_a.key;
        out_nxt.sorted_tag   = rd_a.tag;
        out_nxt.final_res    = (CNT_W'(k_r + 1'b1) == cnt_r);
        out_valid_nxt        = 1'b1;
        state_nxt            = S_OHOLD;
      end
      S_OHOLD: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (out_r.final_res) begin
            cnt_nxt   = '0;
            sp_nxt    = '0;
            state_nxt = S_LOAD;
          end else begin
            ra_a      = IDX_W'(k_r + 1'b1);
            k_nxt     = CNT_W'(k_r + 1'b1);
            state_nxt = S_OWAIT;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sp_r        <= sp_nxt;
      out_valid_r <= out_valid_nxt;
    end
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    k_r     <= k_nxt;
    pivot_r <= pivot_nxt;
    out_r   <= out_nxt;
  end

  assign in_ready  = (state_r == S_LOAD);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Loading and emitting never overlap.
  `DKTQS_ASSERT_NOW(a_no_overlap, clk, rst_n, 1'b1, !(in_ready && out_valid), "load and emit overlap")

  // Pending ranges are disjoint and hold two or more pairs each.
  `DKTQS_ASSERT_NOW(a_stack_bound, clk, rst_n, 1'b1, sp_r <= CNT_W'(MAX_ITEMS / 2), "range stack too deep")

  // The Lomuto boundary never passes the scan index.
  `DKTQS_ASSERT_NOW(a_i_le_j, clk, rst_n, (state_r == S_RD) || (state_r == S_CMP) || (state_r == S_SWJ), i_r <= j_r, "partition index order broken")

  // Taking the final result reopens the input.
  `DKTQS_ASSERT_NEXT(a_reopen, clk, rst_n, out_valid && out_ready && out_data.final_res, in_ready, "input not reopened after set")

endmodule
`default_nettype wire

// ===== design/dktqs_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module dktqs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write, and register the read data; a same-cycle read returns the old word.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire
